[design/c6502alu_pkg.sv]
// Shared types, command codes and constants of the CMOS 6502 ALU.
package c6502alu_pkg;

    typedef enum logic [4:0] {
        CMD_ADC  = 5'd0,
        CMD_SBC  = 5'd1,
        CMD_AND  = 5'd2,
        CMD_ORA  = 5'd3,
        CMD_EOR  = 5'd4,
        CMD_CMP  = 5'd5,
        CMD_ASL  = 5'd6,
        CMD_ROL  = 5'd7,
        CMD_LSR  = 5'd8,
        CMD_ROR  = 5'd9,
        CMD_INC  = 5'd10,
        CMD_DEC  = 5'd11,
        CMD_TRB  = 5'd12,
        CMD_TSB  = 5'd13,
        CMD_RMB  = 5'd14,
        CMD_SMB  = 5'd15,
        CMD_BIT  = 5'd16,
        CMD_BITI = 5'd17
    } t_cmd;

    localparam int FL_N = 7;
    localparam int FL_V = 6;
    localparam int FL_U = 5;
    localparam int FL_D = 3;
    localparam int FL_Z = 1;
    localparam int FL_C = 0;

    localparam logic [7:0] NIB_HI     = 8'hf0;
    localparam logic [7:0] DEC_ADJ_LO = 8'h06;
    localparam logic [7:0] DEC_ADJ_HI = 8'h60;
    localparam logic [9:0] DEC_LIMIT  = 10'h09f;

    typedef struct packed {
        logic [4:0] command;
        logic [7:0] accumulator;
        logic [7:0] compare_register;
        logic [7:0] operand;
        logic [2:0] bit_index;
        logic [7:0] status_in;
    } t_alu_in;

    typedef struct packed {
        logic [7:0] result;
        logic [7:0] status_out;
    } t_alu_out;

endpackage

[design/c6502alu_if.sv]
// Valid/ready channel interfaces for ALU operations and results.
interface c6502alu_in_if;
    logic       valid;
    logic       ready;
    logic [4:0] command;
    logic [7:0] accumulator;
    logic [7:0] compare_register;
    logic [7:0] operand;
    logic [2:0] bit_index;
    logic [7:0] status_in;

    modport source(output valid, command, accumulator, compare_register, operand,
                   bit_index, status_in, input ready);
    modport sink(input valid, command, accumulator, compare_register, operand,
                 bit_index, status_in, output ready);
endinterface

interface c6502alu_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] result;
    logic [7:0] status_out;

    modport source(output valid, result, status_out, input ready);
    modport sink(input valid, result, status_out, output ready);
endinterface

[design/c6502alu_core.sv]
// Combinational ALU datapath: binary/decimal add and subtract, logic, compare, shifts, inc/dec, bit ops.
module c6502alu_core (
    input  c6502alu_pkg::t_alu_in  i_op,
    output c6502alu_pkg::t_alu_out o_res
);
    import c6502alu_pkg::*;

    function automatic logic [7:0] put_nz(input logic [7:0] p, input logic [7:0] v);
        logic [7:0] q;
        q       = p;
        q[FL_Z] = (v == 8'd0);
        q[FL_N] = v[7];
        return q;
    endfunction

    logic [7:0] a, m, p, r, cmp_diff, bmask;
    logic       cin;
    logic [8:0] add9, sub9, cmp9;
    logic [4:0] lo_add, lo_sub, lo_adj;
    logic [9:0] dres, dfix;
    logic [7:0] dsub8;
    logic       v_add_bin, v_add_dec, v_sub;
    t_cmd       cmd;

    always_comb begin
        a     = i_op.accumulator;
        m     = i_op.operand;
        p     = i_op.status_in;
        cin   = p[FL_C];
        cmd   = t_cmd'(i_op.command);
        bmask = 8'd1 << i_op.bit_index;

        add9   = {1'b0, a} + {1'b0, m} + {8'd0, cin};
        sub9   = {1'b0, a} + {1'b0, ~m} + {8'd0, cin};
        cmp9   = {1'b0, i_op.compare_register} + {1'b0, ~m} + 9'd1;
        cmp_diff = cmp9[7:0];
        lo_add = {1'b0, a[3:0]} + {1'b0, m[3:0]} + {4'd0, cin};
        lo_sub = {1'b0, a[3:0]} + {1'b0, ~m[3:0]} + {4'd0, cin};

        // decimal add: low nibble fix, then high nibble fix
        lo_adj = (lo_add > 5'd9) ? {1'b1, lo_add[3:0] + 4'd6} : lo_add;
        dres   = {2'b0, a & NIB_HI} + {2'b0, m & NIB_HI} + {5'd0, lo_adj};
        dfix   = (dres > DEC_LIMIT) ? dres + {2'b0, DEC_ADJ_HI} : dres;

        // decimal subtract: borrow from nibble / byte selects the fix
        dsub8 = sub9[7:0] - (lo_sub[4] ? 8'd0 : DEC_ADJ_LO)
                          - (sub9[8]   ? 8'd0 : DEC_ADJ_HI);

        v_add_bin = ~(a[7] ^ m[7]) & (a[7] ^ add9[7]);
        v_add_dec = ~(a[7] ^ m[7]) & (a[7] ^ dres[7]);
        v_sub     =  (a[7] ^ m[7]) & (a[7] ^ sub9[7]);

        r = a;
        unique case (cmd) inside
            CMD_ADC: begin
                if (p[FL_D]) begin
                    r       = dfix[7:0];
                    p[FL_V] = v_add_dec;
                    p[FL_C] = dfix[9] | dfix[8];
                end else begin
                    r       = add9[7:0];
                    p[FL_V] = v_add_bin;
                    p[FL_C] = add9[8];
                end
                p = put_nz(p, r);
            end
            CMD_SBC: begin
                r       = p[FL_D] ? dsub8 : sub9[7:0];
                p[FL_V] = v_sub;
                p[FL_C] = sub9[8];
                p       = put_nz(p, r);
            end
            CMD_AND: begin
                r = a & m;
                p = put_nz(p, r);
            end
            CMD_ORA: begin
                r = a | m;
                p = put_nz(p, r);
            end
            CMD_EOR: begin
                r = a ^ m;
                p = put_nz(p, r);
            end
            CMD_CMP: begin
                p[FL_C] = cmp9[8];
                p       = put_nz(p, cmp_diff);
            end
            CMD_ASL, CMD_ROL: begin
                r       = {m[6:0], (cmd == CMD_ROL) ? cin : 1'b0};
                p[FL_C] = m[7];
                p       = put_nz(p, r);
            end
            CMD_LSR, CMD_ROR: begin
                r       = {(cmd == CMD_ROR) ? cin : 1'b0, m[7:1]};
                p[FL_C] = m[0];
                p       = put_nz(p, r);
            end
            CMD_INC: begin
                r = m + 8'd1;
                p = put_nz(p, r);
            end
            CMD_DEC: begin
                r = m - 8'd1;
                p = put_nz(p, r);
            end
            CMD_TRB, CMD_TSB: begin
                r       = (cmd == CMD_TRB) ? (m & ~a) : (m | a);
                p[FL_Z] = ((m & a) == 8'd0);
            end
            CMD_RMB: r = m & ~bmask;
            CMD_SMB: r = m | bmask;
            CMD_BIT, CMD_BITI: begin
                p[FL_Z] = ((m & a) == 8'd0);
                if (cmd == CMD_BIT) begin
                    p[FL_N] = m[7];
                    p[FL_V] = m[6];
                end
            end
            default: r = a;
        endcase
        p[FL_U] = 1'b1;

        o_res.result     = r;
        o_res.status_out = p;
    end

endmodule

[design/cmos_6502_alu.sv]
// Top level of the CMOS 6502 ALU: input register, datapath, result register.
// Each operation is held in the input register, then its result in the result register.
// One operation per cycle unless stalled; both stages advance when the result is taken.
// Input ready drops only when both stages hold an item and the result is stalled.
// Reset (i_rst_n low, synchronous) empties both stages; payload is not cleared.
module cmos_6502_alu (
    input  logic            i_clk,
    input  logic            i_rst_n,
    c6502alu_in_if.sink     i_in,
    c6502alu_out_if.source  o_out
);
    import c6502alu_pkg::*;

    logic     r_s1_vld;
    t_alu_in  r_s1;
    logic     r_out_vld;
    t_alu_out r_out;
    t_alu_out n_out;
    logic     advance;

    assign advance  = !r_out_vld || o_out.ready;
    assign i_in.ready = !r_s1_vld || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (i_in.ready) begin
            r_s1_vld <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_s1.command          <= i_in.command;
            r_s1.accumulator      <= i_in.accumulator;
            r_s1.compare_register <= i_in.compare_register;
            r_s1.operand          <= i_in.operand;
            r_s1.bit_index        <= i_in.bit_index;
            r_s1.status_in        <= i_in.status_in;
        end
    end

    c6502alu_core u_core (
        .i_op  (r_s1),
        .o_res (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (advance) begin
            r_out_vld <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_s1_vld) begin
            r_out <= n_out;
        end
    end

    assign o_out.valid      = r_out_vld;
    assign o_out.result     = r_out.result;
    assign o_out.status_out = r_out.status_out;

`ifndef ASSERT_OFF
    a_unused_flag_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> o_out.status_out[FL_U])
        else $error("status bit 5 clear on a valid result");

    a_ready_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in.ready |-> (r_s1_vld && r_out_vld))
        else $error("input stalled while a stage is empty");

    a_stage_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_vld && advance) |=> r_out_vld)
        else $error("item lost between input and result register");

    a_bitop_keeps_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_vld && advance && (r_s1.command == CMD_RMB || r_s1.command == CMD_SMB))
        |=> (o_out.status_out == ($past(r_s1.status_in) | 8'h20)))
        else $error("RMB/SMB changed a flag");
`endif

endmodule

[tb/cmos_6502_alu_tb.sv]
// Regression bench for the CMOS 6502 ALU: directed, random and back-pressure tests.
`timescale 1ns / 100ps

module cmos_6502_alu_tb;
    import c6502alu_pkg::*;

    localparam int         WATCHDOG_LIMIT = 1000;
    localparam int         TAIL_CYCLES    = 8;
    localparam logic [4:0] CMD_RAW_MAX    = 5'd31;
    localparam logic [7:0] ST_C           = 8'h01 << FL_C;
    localparam logic [7:0] ST_D           = 8'h01 << FL_D;

    logic i_clk;
    logic i_rst_n;

    c6502alu_in_if  in_ch ();
    c6502alu_out_if out_ch ();

    cmos_6502_alu dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    t_alu_out pending_results[$];
    t_alu_out head_result;
    int       mismatch_count;
    int       idle_cycles;
    int       rx_hold_len;
    bit       rx_idle_en;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic logic [7:0] put_nz(input logic [7:0] p, input logic [7:0] v);
        p[FL_Z] = (v == 8'h00);
        p[FL_N] = v[7];
        return p;
    endfunction

    function automatic t_alu_out alu_predict(input t_alu_in op);
        logic [7:0] a;
        logic [7:0] m;
        logic [7:0] cr;
        logic [7:0] p;
        logic [7:0] r;
        logic [7:0] ov;
        logic       c_old;
        bit         sub;
        int         cin;
        int         bin;
        int         low;
        int         sum;
        t_alu_out   res;
        a     = op.accumulator;
        m     = op.operand;
        cr    = op.compare_register;
        p     = op.status_in;
        r     = a;
        c_old = p[FL_C];
        case (op.command)
            CMD_ADC, CMD_SBC: begin
                sub = (op.command == CMD_SBC);
                cin = int'(c_old);
                bin = sub ? int'(a) - int'(m) - (1 - cin) : int'(a) + int'(m) + cin;
                if (!p[FL_D]) begin
                    ov = sub ? ((a ^ m) & (a ^ bin[7:0])) : (~(a ^ m) & (a ^ bin[7:0]));
                    p[FL_V] = ov[7];
                    p[FL_C] = sub ? (bin >= 0) : (bin > 255);
                    sum = bin;
                end else if (sub) begin
                    low = int'(a[3:0]) - int'(m[3:0]) - (1 - cin);
                    ov = (a ^ m) & (a ^ bin[7:0]);
                    p[FL_V] = ov[7];
                    sum = bin;
                    if (low < 0) sum -= int'(DEC_ADJ_LO);
                    if (bin < 0) sum -= int'(DEC_ADJ_HI);
                    p[FL_C] = (bin >= 0);
                end else begin
                    low = int'(a[3:0]) + int'(m[3:0]) + cin;
                    if (low > 9) low = ((low + int'(DEC_ADJ_LO)) & 15) + 16;
                    sum = int'(a & NIB_HI) + int'(m & NIB_HI) + low;
                    ov = ~(a ^ m) & (a ^ sum[7:0]);
                    p[FL_V] = ov[7];
                    if (sum > int'(DEC_LIMIT)) sum += int'(DEC_ADJ_HI);
                    p[FL_C] = (sum > 255);
                end
                r = sum[7:0];
                p = put_nz(p, r);
            end
            CMD_AND: begin
                r = a & m;
                p = put_nz(p, r);
            end
            CMD_ORA: begin
                r = a | m;
                p = put_nz(p, r);
            end
            CMD_EOR: begin
                r = a ^ m;
                p = put_nz(p, r);
            end
            CMD_CMP: begin
                p[FL_C] = (cr >= m);
                p = put_nz(p, cr - m);
            end
            CMD_ASL, CMD_ROL: begin
                p[FL_C] = m[7];
                r = {m[6:0], (op.command == CMD_ROL) ? c_old : 1'b0};
                p = put_nz(p, r);
            end
            CMD_LSR, CMD_ROR: begin
                p[FL_C] = m[0];
                r = {(op.command == CMD_ROR) ? c_old : 1'b0, m[7:1]};
                p = put_nz(p, r);
            end
            CMD_INC: begin
                r = m + 8'd1;
                p = put_nz(p, r);
            end
            CMD_DEC: begin
                r = m - 8'd1;
                p = put_nz(p, r);
            end
            CMD_TRB, CMD_TSB: begin
                p[FL_Z] = ((m & a) == 8'h00);
                r = (op.command == CMD_TRB) ? (m & ~a) : (m | a);
            end
            CMD_RMB: begin
                r = m;
                r[op.bit_index] = 1'b0;
            end
            CMD_SMB: begin
                r = m;
                r[op.bit_index] = 1'b1;
            end
            CMD_BIT, CMD_BITI: begin
                p[FL_Z] = ((a & m) == 8'h00);
                if (op.command == CMD_BIT) begin
                    p[FL_N] = m[7];
                    p[FL_V] = m[6];
                end
            end
            default: begin
            end
        endcase
        p[FL_U] = 1'b1;
        res.result     = r;
        res.status_out = p;
        return res;
    endfunction

    function automatic t_alu_in mk_op(input logic [4:0] cmd, input logic [7:0] a,
                                      input logic [7:0] cr, input logic [7:0] m,
                                      input logic [2:0] bi, input logic [7:0] p);
        t_alu_in op;
        op.command          = cmd;
        op.accumulator      = a;
        op.compare_register = cr;
        op.operand          = m;
        op.bit_index        = bi;
        op.status_in        = p;
        return op;
    endfunction

    function automatic logic [7:0] rand_bcd();
        return {4'($urandom_range(0, 9)), 4'($urandom_range(0, 9))};
    endfunction

    function automatic t_alu_in rand_op();
        t_alu_in op;
        if ($urandom_range(0, 19) < 18)
            op.command = 5'($urandom_range(CMD_ADC, CMD_BITI));
        else
            op.command = 5'($urandom_range(CMD_BITI + 1, CMD_RAW_MAX));
        op.accumulator      = 8'($urandom);
        op.compare_register = 8'($urandom);
        op.operand          = 8'($urandom);
        op.bit_index        = 3'($urandom);
        op.status_in        = 8'($urandom);
        if ((op.command == CMD_ADC || op.command == CMD_SBC) && $urandom_range(0, 1)) begin
            op.accumulator = rand_bcd();
            op.operand     = rand_bcd();
        end
        return op;
    endfunction

    // mostly short, a few long
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 70) return 0;
        if (roll < 95) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // caller is always right after a rising edge; valid stays high after the transfer
    task automatic send_op(input t_alu_in op, input int gap);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid            <= 1'b1;
        in_ch.command          <= op.command;
        in_ch.accumulator      <= op.accumulator;
        in_ch.compare_register <= op.compare_register;
        in_ch.operand          <= op.operand;
        in_ch.bit_index        <= op.bit_index;
        in_ch.status_in        <= op.status_in;
        do @(posedge i_clk); while (!in_ch.ready);
        pending_results.push_back(alu_predict(op));
    endtask

    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_edge_values();
        t_alu_in ops[$];
        ops.push_back(mk_op(CMD_ADC, 8'h7f, 8'h00, 8'h01, 3'd0, 8'h00));
        ops.push_back(mk_op(CMD_ADC, 8'hff, 8'h00, 8'h01, 3'd0, ST_C));
        ops.push_back(mk_op(CMD_ADC, 8'h99, 8'h00, 8'h01, 3'd0, ST_D));
        ops.push_back(mk_op(CMD_ADC, 8'hff, 8'h00, 8'hff, 3'd0, ST_D | ST_C));
        ops.push_back(mk_op(CMD_SBC, 8'h80, 8'h00, 8'h01, 3'd0, ST_C));
        ops.push_back(mk_op(CMD_SBC, 8'h00, 8'h00, 8'h00, 3'd0, 8'h00));
        ops.push_back(mk_op(CMD_SBC, 8'h00, 8'h00, 8'h01, 3'd0, ST_D | ST_C));
        ops.push_back(mk_op(CMD_SBC, 8'hfa, 8'h00, 8'haf, 3'd0, ST_D));
        ops.push_back(mk_op(CMD_AND, 8'hff, 8'h00, 8'h00, 3'd0, 8'hff));
        ops.push_back(mk_op(CMD_ORA, 8'h80, 8'h00, 8'h00, 3'd0, 8'h00));
        ops.push_back(mk_op(CMD_EOR, 8'hff, 8'h00, 8'hff, 3'd0, 8'h00));
        ops.push_back(mk_op(CMD_CMP, 8'h12, 8'h40, 8'h40, 3'd0, 8'h00));
        ops.push_back(mk_op(CMD_CMP, 8'hff, 8'h00, 8'hff, 3'd0, 8'hff));
        ops.push_back(mk_op(CMD_ASL, 8'h00, 8'h00, 8'h80, 3'd0, ST_C));
        ops.push_back(mk_op(CMD_ROL, 8'h00, 8'h00, 8'h80, 3'd0, ST_C));
        ops.push_back(mk_op(CMD_LSR, 8'h00, 8'h00, 8'h01, 3'd0, ST_C));
        ops.push_back(mk_op(CMD_ROR, 8'h00, 8'h00, 8'h01, 3'd0, ST_C));
        ops.push_back(mk_op(CMD_INC, 8'h00, 8'h00, 8'hff, 3'd0, 8'h00));
        ops.push_back(mk_op(CMD_DEC, 8'h00, 8'h00, 8'h00, 3'd0, 8'h00));
        ops.push_back(mk_op(CMD_TRB, 8'hf0, 8'h00, 8'hff, 3'd0, 8'hff));
        ops.push_back(mk_op(CMD_TSB, 8'h00, 8'h00, 8'h00, 3'd0, 8'h00));
        ops.push_back(mk_op(CMD_RMB, 8'h00, 8'h00, 8'hff, 3'd7, 8'hff));
        ops.push_back(mk_op(CMD_SMB, 8'hff, 8'h00, 8'h00, 3'd0, 8'h00));
        ops.push_back(mk_op(CMD_BIT, 8'h00, 8'h00, 8'hc0, 3'd0, 8'h00));
        ops.push_back(mk_op(CMD_BITI, 8'h0f, 8'h00, 8'hf0, 3'd0, 8'hff));
        ops.push_back(mk_op(CMD_RAW_MAX, 8'h5a, 8'hff, 8'hff, 3'd7, 8'h00));
        foreach (ops[i]) send_op(ops[i], 0);
        wait_drained();
    endtask

    task automatic test_random_ops(input int count, input bit with_idle);
        rx_idle_en = with_idle;
        repeat (count) send_op(rand_op(), with_idle ? pick_gap() : 0);
    endtask

    // receiver holds off while the sender keeps offering back to back
    task automatic test_backpressure(input int count);
        rx_idle_en  = 1'b0;
        rx_hold_len = 80;
        repeat (count) send_op(rand_op(), 0);
        wait_drained();
    endtask

    // result side
    initial begin
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (rx_hold_len > 0) begin
                out_ch.ready <= 1'b0;
                repeat (rx_hold_len) @(posedge i_clk);
                rx_hold_len = 0;
                out_ch.ready <= 1'b1;
            end else if (rx_idle_en && $urandom_range(0, 3) == 0) begin
                out_ch.ready <= 1'b0;
                repeat ((pick_gap() % 30) + 1) @(posedge i_clk);
                out_ch.ready <= 1'b1;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (pending_results.size() == 0) begin
                mismatch_count++;
                $display("%0t: unexpected result: result %02h status %02h", $time,
                         out_ch.result, out_ch.status_out);
            end else begin
                head_result = pending_results.pop_front();
                if (out_ch.result !== head_result.result) begin
                    mismatch_count++;
                    $display("%0t: result mismatch: expected %02h actual %02h", $time,
                             head_result.result, out_ch.result);
                end
                if (out_ch.status_out !== head_result.status_out) begin
                    mismatch_count++;
                    $display("%0t: status mismatch: expected %02h actual %02h", $time,
                             head_result.status_out, out_ch.status_out);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, idle_cycles);
            $display("cmos_6502_alu regression: fail");
            $finish;
        end
    end

    initial begin
        mismatch_count          = 0;
        idle_cycles             = 0;
        rx_hold_len             = 0;
        rx_idle_en              = 1'b0;
        i_rst_n                <= 1'b0;
        in_ch.valid            <= 1'b0;
        in_ch.command          <= CMD_ADC;
        in_ch.accumulator      <= 8'h00;
        in_ch.compare_register <= 8'h00;
        in_ch.operand          <= 8'h00;
        in_ch.bit_index        <= 3'd0;
        in_ch.status_in        <= 8'h00;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_edge_values();
        test_random_ops(300, 1'b0);
        test_backpressure(30);
        test_random_ops(1600, 1'b1);

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("cmos_6502_alu regression: pass");
        else
            $display("cmos_6502_alu regression: fail");
        $finish;
    end

endmodule

[sim.f]
design/c6502alu_pkg.sv
design/c6502alu_if.sv
design/c6502alu_core.sv
design/cmos_6502_alu.sv
tb/cmos_6502_alu_tb.sv
